/* rtl/radix2_dit_fft_top_assert.svh */
`ifndef RADIX2_DIT_FFT_TOP_ASSERT_SVH
`define RADIX2_DIT_FFT_TOP_ASSERT_SVH
// implication check under reset
`define A_IMPL(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error("lbl");
// next-cycle check under reset
`define A_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error("lbl");
`endif

/* rtl/r2fft_pkg.sv */
package r2fft_pkg;
    localparam int MAX_POINTS   = 64;
    localparam int SAMPLE_BITS  = 16;
    localparam int TWIDDLE_BITS = 16;
    localparam int ACC_BITS     = 23;
    localparam int CIRCLE       = 64;

    typedef enum logic [2:0] {
        t_S_LOAD, t_S_RDB, t_S_RDA, t_S_MUL, t_S_WR, t_S_OUT
    } t_state;

    function automatic logic [23:0] quarter_sine(input logic [4:0] q);
        case (q)
            5'd0:  quarter_sine = 24'd0;
            5'd1:  quarter_sine = 24'd822227;
            5'd2:  quarter_sine = 24'd1636536;
            5'd3:  quarter_sine = 24'd2435084;
            5'd4:  quarter_sine = 24'd3210181;
            5'd5:  quarter_sine = 24'd3954362;
            5'd6:  quarter_sine = 24'd4660461;
            5'd7:  quarter_sine = 24'd5321678;
            5'd8:  quarter_sine = 24'd5931642;
            5'd9:  quarter_sine = 24'd6484482;
            5'd10: quarter_sine = 24'd6974873;
            5'd11: quarter_sine = 24'd7398092;
            5'd12: quarter_sine = 24'd7750063;
            5'd13: quarter_sine = 24'd8027397;
            5'd14: quarter_sine = 24'd8227423;
            5'd15: quarter_sine = 24'd8348215;
            default: quarter_sine = 24'd8388608;
        endcase
    endfunction

    // sine on a 64 point circle, Q.23, 25 bit signed
    function automatic logic signed [24:0] sine23(input logic [5:0] k);
        logic [4:0] q;
        logic neg;
        logic signed [24:0] m;
        begin
            neg = k[5];
            if (k[4]) begin
                q = 5'd16 - {1'b0, k[3:0]};
            end else begin
                q = {1'b0, k[3:0]};
            end
            m = $signed({1'b0, quarter_sine(q)});
            sine23 = neg ? -m : m;
        end
    endfunction

    function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [47:0] v);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        begin
            hi = (48'sd1 <<< (ACC_BITS - 1)) - 48'sd1;
            lo = -(48'sd1 <<< (ACC_BITS - 1));
            if (v > hi) begin
                sat_acc = hi[ACC_BITS-1:0];
            end else if (v < lo) begin
                sat_acc = lo[ACC_BITS-1:0];
            end else begin
                sat_acc = v[ACC_BITS-1:0];
            end
        end
    endfunction
endpackage

/* rtl/radix2_dit_fft_top.sv */
// Load: one word per cycle, n words. Transform: each butterfly steps through RDB,
// RDA, MUL and WR; (n/2)*log2(n) butterflies through one shared butterfly unit and
// one store port. Drain: n result words, each read, then presented until taken.
// Synchronous active-low reset: size 64, word count cleared; store undefined.
module radix2_dit_fft_top #(
    parameter int MAX_POINTS   = r2fft_pkg::MAX_POINTS,
    parameter int SAMPLE_BITS  = r2fft_pkg::SAMPLE_BITS,
    parameter int TWIDDLE_BITS = r2fft_pkg::TWIDDLE_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [2:0]                            i_cfg_wdata,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample_re,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample_im,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [r2fft_pkg::ACC_BITS-1:0] o_result_re,
    output logic signed [r2fft_pkg::ACC_BITS-1:0] o_result_im,
    output logic                                  o_last_result
);
    import r2fft_pkg::*;
    localparam int LG_MAX = $clog2(MAX_POINTS);
    localparam int AW = (LG_MAX < 1) ? 1 : LG_MAX;
    localparam int DEPTH = 1 << AW;

    t_state r_state, n_state;
    logic [2:0] r_lg;
    logic [2:0] lg;
    logic [AW:0] r_cnt, n_cnt;
    logic [2:0] r_s, n_s;
    logic [AW-1:0] r_j, n_j;
    logic [AW:0] npts;

    logic signed [ACC_BITS-1:0] mem_re [DEPTH];
    logic signed [ACC_BITS-1:0] mem_im [DEPTH];
    logic signed [ACC_BITS-1:0] r_rd_re, r_rd_im, r_br, r_bi;
    logic [AW-1:0] rd_addr, a_addr, b_addr, ld_addr;
    logic [5:0] tw_k;
    logic in_acc, out_acc, wr_a, wr_b;
    logic signed [ACC_BITS-1:0] pr, pim, mr, mim;
    logic signed [ACC_BITS-1:0] in_re, in_im;
    logic signed [ACC_BITS-1:0] r_mr, r_mi;
    logic [AW-1:0] r_wb_addr;
    logic r_wb;

    always_comb begin
        lg = r_lg;
        if (lg < 3'd1) lg = 3'd1;
        if (32'(lg) > LG_MAX) lg = 3'(LG_MAX);
    end
    assign npts = (AW+1)'(1) << lg;

    // butterfly j in stage s: half = 2^(s-1); a = group base + offset
    logic [AW-1:0] half, offs;
    assign half = AW'(1) << (r_s - 3'd1);
    assign offs = r_j & (half - AW'(1));
    assign a_addr = ((r_j & ~(half - AW'(1))) << 1) | offs;
    assign b_addr = a_addr | half;
    assign tw_k = 6'((32'(offs) * CIRCLE) >> r_s);

    always_comb begin
        ld_addr = '0;
        for (int i = 0; i < AW; i++) begin
            if (i < 32'(lg)) ld_addr[i] = r_cnt[32'(lg) - 1 - i];
        end
    end

    assign in_acc = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign in_re = sat_acc(48'(i_sample_re));
    assign in_im = sat_acc(48'(i_sample_im));

    r2fft_bfly #(.TW_BITS(TWIDDLE_BITS)) u_bfly (
        .i_clk(i_clk), .i_mul(r_state == t_S_MUL), .i_k(tw_k),
        .i_br(r_br), .i_bi(r_bi), .i_ar(r_rd_re), .i_ai(r_rd_im),
        .o_pr(pr), .o_pi(pim), .o_mr(mr), .o_mi(mim)
    );

    always_comb begin
        case (r_state)
            t_S_RDB: rd_addr = b_addr;
            t_S_OUT: rd_addr = r_cnt[AW-1:0];
            default: rd_addr = a_addr;
        endcase
    end
    assign wr_a = (r_state == t_S_WR);
    assign wr_b = r_wb;

    always_ff @(posedge i_clk) begin
        if (r_state == t_S_LOAD && in_acc) begin
            mem_re[ld_addr] <= in_re;
            mem_im[ld_addr] <= in_im;
        end else if (wr_b) begin
            mem_re[r_wb_addr] <= r_mr;
            mem_im[r_wb_addr] <= r_mi;
        end else if (wr_a) begin
            mem_re[a_addr] <= pr;
            mem_im[a_addr] <= pim;
        end
        r_rd_re <= mem_re[rd_addr];
        r_rd_im <= mem_im[rd_addr];
        if (r_state == t_S_RDA) begin
            r_br <= r_rd_re;
            r_bi <= r_rd_im;
        end
    end

    // b half of a butterfly is held at WR and written the next cycle
    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            r_mr <= mr;
            r_mi <= mim;
            r_wb_addr <= b_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb <= 1'b0;
        end else begin
            r_wb <= wr_a;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_s = r_s;
        n_j = r_j;
        case (r_state)
            t_S_LOAD: begin
                if (in_acc) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt + 1'b1 == npts) begin
                        n_state = t_S_RDB;
                        n_cnt = '0;
                        n_s = 3'd1;
                        n_j = '0;
                    end
                end
            end
            t_S_RDB: n_state = t_S_RDA;
            t_S_RDA: n_state = t_S_MUL;
            t_S_MUL: n_state = t_S_WR;
            t_S_WR: begin
                // the b write of this butterfly lands in the next RDB/OUT cycle
                n_state = t_S_RDB;
                if (32'(r_j) == 32'(npts >> 1) - 1) begin
                    n_j = '0;
                    if (r_s == lg) begin
                        n_state = t_S_OUT;
                        n_cnt = '0;
                    end else begin
                        n_s = r_s + 3'd1;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            t_S_OUT: begin
                if (out_acc) begin
                    n_cnt = r_cnt + 1'b1;
                    if (r_cnt + 1'b1 == npts) begin
                        n_state = t_S_LOAD;
                        n_cnt = '0;
                    end
                end
            end
            default: n_state = t_S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_S_LOAD;
            r_cnt <= '0;
            r_s <= 3'd1;
            r_j <= '0;
            r_lg <= 3'd6;
        end else if (i_cfg_we) begin
            r_lg <= i_cfg_wdata;
            r_state <= t_S_LOAD;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_s <= n_s;
            r_j <= n_j;
        end
    end

    // output word valid once the read of the current index is registered
    logic r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == t_S_OUT && !out_acc) begin
            r_ov <= 1'b1;
        end else begin
            r_ov <= 1'b0;
        end
    end

    always_comb begin
        o_stall = (r_state != t_S_LOAD);
        o_valid = (r_state == t_S_OUT) && r_ov;
        o_result_re = r_rd_re;
        o_result_im = r_rd_im;
        o_last_result = (r_cnt == npts - 1'b1);
    end

    `include "radix2_dit_fft_top_assert.svh"
    `A_IMPL(a_no_out_in_load, r_state == t_S_LOAD, !o_valid)
    `A_NEXT(a_out_drop, out_acc, !o_valid)
    `A_IMPL(a_last_in_out, o_valid && o_last_result, r_state == t_S_OUT)
endmodule

/* rtl/r2fft_bfly.sv */
module r2fft_bfly #(
    parameter int TW_BITS = r2fft_pkg::TWIDDLE_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_mul,
    input  logic [5:0]                             i_k,
    input  logic signed [r2fft_pkg::ACC_BITS-1:0]  i_br,
    input  logic signed [r2fft_pkg::ACC_BITS-1:0]  i_bi,
    input  logic signed [r2fft_pkg::ACC_BITS-1:0]  i_ar,
    input  logic signed [r2fft_pkg::ACC_BITS-1:0]  i_ai,
    output logic signed [r2fft_pkg::ACC_BITS-1:0]  o_pr,
    output logic signed [r2fft_pkg::ACC_BITS-1:0]  o_pi,
    output logic signed [r2fft_pkg::ACC_BITS-1:0]  o_mr,
    output logic signed [r2fft_pkg::ACC_BITS-1:0]  o_mi
);
    import r2fft_pkg::*;
    localparam int PW = ACC_BITS + TW_BITS + 1;

    // Q.23 sine rounded half up to Q1.(TW_BITS-1), +1.0 saturated
    function automatic logic signed [TW_BITS-1:0] scale_tw(input logic signed [24:0] v);
        localparam int SH = 24 - TW_BITS;
        logic signed [25:0] r;
        logic signed [25:0] hi;
        begin
            hi = 26'sd1 <<< (TW_BITS - 1);
            hi = hi - 26'sd1;
            if (SH == 0) begin
                r = 26'(v);
            end else begin
                r = (26'(v) + (26'sd1 <<< (SH > 0 ? SH - 1 : 0))) >>> SH;
            end
            if (r > hi) begin
                r = hi;
            end
            scale_tw = r[TW_BITS-1:0];
        end
    endfunction

    logic signed [TW_BITS-1:0] wr, wi;
    logic signed [PW-1:0] r_tr, r_ti;
    logic signed [PW-1:0] n_tr, n_ti;
    logic signed [PW-1:0] rnd;

    assign wr = scale_tw(sine23(i_k + 6'd16));
    assign wi = scale_tw(sine23(i_k));
    assign rnd = PW'(1) <<< (TW_BITS - 2);

    always_comb begin
        n_tr = (PW'(i_br) * PW'(wr) - PW'(i_bi) * PW'(wi) + rnd) >>> (TW_BITS - 1);
        n_ti = (PW'(i_br) * PW'(wi) + PW'(i_bi) * PW'(wr) + rnd) >>> (TW_BITS - 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_mul) begin
            r_tr <= n_tr;
            r_ti <= n_ti;
        end
    end

    assign o_pr = sat_acc(48'(i_ar) + 48'(r_tr));
    assign o_pi = sat_acc(48'(i_ai) + 48'(r_ti));
    assign o_mr = sat_acc(48'(i_ar) - 48'(r_tr));
    assign o_mi = sat_acc(48'(i_ai) - 48'(r_ti));
endmodule
